@@ design/stbs_pkg.sv @@
// ---------------------------------------------------------------------------
// stbs_pkg
// Shared constants, op codes and controller/datapath interface types for the
// sorted table binary search block.
// ---------------------------------------------------------------------------
package stbs_pkg;

    localparam int OP_W          = 2;
    localparam int IDX_W         = 10;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 11;
    localparam int POS_W         = 10;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_EXACT = 2'd1;
    localparam logic [OP_W-1:0] OP_FIRST = 2'd2;
    localparam logic [OP_W-1:0] OP_LAST  = 2'd3;

    typedef struct packed {
        logic load;
        logic start;
        logic probe;
        logic set_res;
        logic res_found;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic hit;
        logic exact_hit;
        logic cont;
        logic final_ok;
        logic out_free;
    } t_status;

endpackage

@@ design/stbs_ram.sv @@
// ---------------------------------------------------------------------------
// stbs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/stbs_dpath.sv @@
// ---------------------------------------------------------------------------
// stbs_dpath
// Search datapath: count register, key, lo/hi bounds, probe address, compare,
// result and output registers.
// ---------------------------------------------------------------------------
module stbs_dpath import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [CNT_W-1:0]               i_cfg_wr_data,
    input  logic [OP_W-1:0]                i_op,
    input  logic [IDX_W-1:0]               i_entry_index,
    input  logic signed [DATA_W-1:0]       i_data_value,
    input  logic                           i_out_stall,
    input  t_cmd                           i_cmd,
    output t_status                        o_status,
    output logic                           o_ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_waddr,
    output logic [DATA_W-1:0]              o_ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_raddr,
    input  logic [DATA_W-1:0]              i_ram_rdata,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [POS_W-1:0]               o_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int LW = CW + 1;
    localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int XW = (AW > POS_W) ? AW : POS_W;
    localparam logic signed [LW-1:0] ONE_S = LW'(1);

    logic [CNT_W-1:0]         r_entries;
    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_key;
    logic signed [LW-1:0]     r_lo;
    logic signed [LW-1:0]     r_hi;
    logic [AW-1:0]            r_mid;
    logic                     r_res_found;
    logic [POS_W-1:0]         r_res_pos;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [POS_W-1:0]         r_out_pos;

    logic [CW-1:0]            count;
    logic [CW-1:0]            count_m1;
    logic signed [LW-1:0]     count_s;
    logic signed [LW-1:0]     mid_s;
    logic signed [LW-1:0]     n_lo;
    logic signed [LW-1:0]     n_hi;
    logic [LW:0]              bound_sum;
    logic [AW-1:0]            n_mid;
    logic [AW-1:0]            start_mid;
    logic [AW-1:0]            final_addr;
    logic [AW-1:0]            rd_addr;
    logic                     hit;
    logic                     less;
    logic                     cont;
    logic                     final_ok;
    logic [XW-1:0]            idx_x;
    logic [XW-1:0]            mid_x;

    always_comb begin
        if (CW'(r_entries) > CW'(TABLE_DEPTH)) begin
            count = CW'(TABLE_DEPTH);
        end else begin
            count = CW'(r_entries);
        end
    end

    assign count_m1  = count - CW'(1);
    assign count_s   = $signed({1'b0, count});
    assign start_mid = count_m1[AW:1];
    assign mid_s     = $signed({{(LW-AW){1'b0}}, r_mid});

    assign hit  = (i_ram_rdata == r_key);
    assign less = ($signed(i_ram_rdata) < r_key);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (hit) begin
            if (r_op == OP_FIRST) begin
                n_hi = mid_s - ONE_S;
            end else begin
                n_lo = mid_s + ONE_S;
            end
        end else if (less) begin
            n_lo = mid_s + ONE_S;
        end else begin
            n_hi = mid_s - ONE_S;
        end
    end

    assign bound_sum = {n_lo[LW-1], n_lo} + {n_hi[LW-1], n_hi};
    assign n_mid     = bound_sum[AW:1];
    assign cont      = (n_lo <= n_hi);

    always_comb begin
        unique case (r_op)
            OP_FIRST: begin
                final_addr = n_lo[AW-1:0];
                final_ok   = (n_lo < count_s);
            end
            OP_LAST: begin
                final_addr = n_hi[AW-1:0];
                final_ok   = !n_hi[LW-1];
            end
            default: begin
                final_addr = n_hi[AW-1:0];
                final_ok   = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.start) begin
            rd_addr = start_mid;
        end else if (cont) begin
            rd_addr = n_mid;
        end else begin
            rd_addr = final_addr;
        end
    end

    assign idx_x = XW'(i_entry_index);
    assign mid_x = XW'(r_mid);

    assign o_ram_we    = i_cmd.load && (i_op == OP_WRITE)
                         && (IW'(i_entry_index) < IW'(TABLE_DEPTH));
    assign o_ram_waddr = idx_x[AW-1:0];
    assign o_ram_wdata = i_data_value;
    assign o_ram_raddr = rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entries <= i_cfg_wr_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_data_value;
        end
        if (i_cmd.start) begin
            r_lo  <= '0;
            r_hi  <= count_s - ONE_S;
            r_mid <= start_mid;
        end else if (i_cmd.probe) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= rd_addr;
        end
        if (i_cmd.set_res) begin
            r_res_found <= i_cmd.res_found;
            r_res_pos   <= i_cmd.res_found ? mid_x[POS_W-1:0] : '0;
        end
        if (i_cmd.load_out) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
        end
    end

    assign o_status.n_zero    = (count == '0);
    assign o_status.hit       = hit;
    assign o_status.exact_hit = hit && (r_op == OP_EXACT);
    assign o_status.cont      = cont;
    assign o_status.final_ok  = final_ok;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule

@@ design/stbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer: accept, start, probe loop, final check, result handoff.
// ---------------------------------------------------------------------------
module stbs_ctrl import stbs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [OP_W-1:0] i_op,
    input  t_status         i_status,
    output t_cmd            o_cmd,
    output logic            o_stall
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_op != OP_WRITE) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                if (i_status.n_zero) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
                priority if (i_status.exact_hit) begin
                    o_cmd.set_res   = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_state         = ST_DONE;
                end else if (i_status.cont) begin
                    n_state = ST_PROBE;
                end else if (i_status.final_ok) begin
                    n_state = ST_FINAL;
                end else begin
                    o_cmd.set_res = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_FINAL: begin
                o_cmd.set_res   = 1'b1;
                o_cmd.res_found = i_status.hit;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

@@ design/sorted_table_binary_search.sv @@
// ---------------------------------------------------------------------------
// sorted_table_binary_search
// Table write: the block stays idle, so the next beat is accepted on the
// following edge. Query: start, probe loop over the searched count (the entry
// count capped at the table depth), final-check read when needed, and output
// load, held while the output stalls; the next beat is accepted back in idle.
// Synchronous active-low reset clears control, count and output valid;
// table contents are undefined until written.
// ---------------------------------------------------------------------------
module sorted_table_binary_search import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CNT_W-1:0]         i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_op,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [DATA_W-1:0] i_data_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_found,
    output logic [POS_W-1:0]         o_position
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_cmd              cmd;
    t_status           status;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_data_value  (i_data_value),
        .i_out_stall   (i_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

@@ design/stbs_checker.sv @@
// ---------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted table binary search block.
// ---------------------------------------------------------------------------
module stbs_checker import stbs_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic [OP_W-1:0]          i_op,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic                     o_found,
    input logic [POS_W-1:0]         o_position
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_found) && $stable(o_position)))
        else $error("result beat changed while stalled");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0))
        else $error("miss with nonzero position");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_op != OP_WRITE)) |=> o_stall)
        else $error("query beat did not start a search");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_op == OP_WRITE)) |=> !o_stall)
        else $error("table write blocked the next beat");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: sorted table binary search testbench
// Loads sorted tables into the block, including the full depth, and sets
// several entry counts: zero, full depth and counts beyond the depth. It then
// issues exact, first-occurrence and last-occurrence searches, starting with
// a directed set and then random phases. A local copy of the table and the
// count predicts each search result. Results are checked in order, with random
// gaps and stalls on both channels and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_top import stbs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SMALL_PHASE_ITEMS = 250;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } t_table_beat;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_result;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]         cfg_wr_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          in_op = OP_WRITE;
    logic [IDX_W-1:0]         in_index = '0;
    logic signed [DATA_W-1:0] in_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     out_found;
    logic [POS_W-1:0]         out_position;

    t_table_beat    table_beats[$];
    t_search_result search_results_due[$];

    logic signed [DATA_W-1:0] mirror_table [TABLE_DEPTH];
    logic [CNT_W-1:0]         entry_count;

    logic signed [DATA_W-1:0] plan_table [TABLE_DEPTH];
    bit                       plan_written [TABLE_DEPTH];
    int                       plan_count;
    int                       stim_items;

    t_table_beat cur_beat;
    int          send_gap;
    bit          send_quiet;
    int          stall_left;
    int          hold_left;
    int          hold_reqs;
    int          hold_served;
    bit          recv_quiet;
    int          fail_count;
    int          cycle_count;

    sorted_table_binary_search i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_op           (in_op),
        .i_entry_index  (in_index),
        .i_data_value   (in_value),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_found        (out_found),
        .o_position     (out_position)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_search_result predict_search(logic [OP_W-1:0] op,
                                                      logic signed [DATA_W-1:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        int hit_at;
        t_search_result res;
        n = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        hit_at = -1;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (mirror_table[mid] == key) begin
                if (op == OP_EXACT) begin
                    hit_at = mid;
                    break;
                end else if (op == OP_FIRST) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end else if (mirror_table[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        if (op == OP_FIRST && lo < n && mirror_table[lo] == key) begin
            hit_at = lo;
        end else if (op == OP_LAST && hi >= 0 && mirror_table[hi] == key) begin
            hit_at = hi;
        end
        res.found = (hit_at >= 0);
        res.position = (hit_at >= 0) ? hit_at[POS_W-1:0] : '0;
        return res;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            entry_count <= '0;
        end else if (cfg_wr_en) begin
            entry_count <= cfg_wr_data;
        end
    end

    // Sender: hold a stalled beat, otherwise advance through the queue.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                if (cur_beat.op == OP_WRITE) begin
                    if (int'(cur_beat.index) < TABLE_DEPTH) begin
                        mirror_table[cur_beat.index] = cur_beat.value;
                    end
                end else begin
                    search_results_due.push_back(predict_search(cur_beat.op, cur_beat.value));
                end
            end
            if (in_valid && in_stall) begin
                in_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (table_beats.size() > 0) begin
                cur_beat = table_beats.pop_front();
                in_op <= cur_beat.op;
                in_index <= cur_beat.index;
                in_value <= cur_beat.value;
                in_valid <= 1'b1;
                send_gap = pick_gap(send_quiet);
            end else begin
                in_valid <= 1'b0;
            end
            if ($urandom_range(0, 99) == 0) begin
                send_quiet = !send_quiet;
            end
        end
    end

    // Receiver: long hold-offs on request, random stalls otherwise.
    always @(posedge clk) begin
        int pause;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_served != hold_reqs) begin
                hold_served++;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                pause = pick_gap(recv_quiet);
                stall_left = (pause > 0) ? pause - 1 : 0;
                out_stall <= (pause > 0);
            end
            if ($urandom_range(0, 99) == 0) begin
                recv_quiet = !recv_quiet;
            end
        end
    end

    always @(posedge clk) begin
        t_search_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (search_results_due.size() == 0) begin
                $error("result beat with none due: found=%0d position=%0d",
                       out_found, out_position);
                fail_count++;
            end else begin
                want = search_results_due.pop_front();
                if (out_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, out_found);
                    fail_count++;
                end
                if (out_position !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position, out_position);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL sorted_table_binary_search");
            $finish;
        end
    end

    task automatic push_write(int idx, logic signed [DATA_W-1:0] val);
        t_table_beat b;
        b.op = OP_WRITE;
        b.index = idx[IDX_W-1:0];
        b.value = val;
        table_beats.push_back(b);
        plan_table[idx] = val;
        plan_written[idx] = 1'b1;
        stim_items++;
    endtask

    task automatic push_query(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] key);
        t_table_beat b;
        b.op = op;
        b.index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        b.value = key;
        table_beats.push_back(b);
        stim_items++;
    endtask

    task automatic wait_drained();
        while (table_beats.size() != 0 || in_valid || search_results_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_count(int v);
        wait_drained();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        plan_count = v;
        @(negedge clk);
    endtask

    function automatic int written_prefix();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (!plan_written[i]) begin
                return i;
            end
        end
        return TABLE_DEPTH;
    endfunction

    task automatic load_sorted(int n);
        longint v;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            v = longint'(VAL_MIN) + $urandom_range(0, 3);
        end else if (r == 1) begin
            v = longint'(VAL_MAX) - $urandom_range(0, 60);
        end else begin
            v = longint'($signed($urandom));
        end
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    v += 0;
                end else if (r < 80) begin
                    v += $urandom_range(1, 20);
                end else begin
                    v += $urandom_range(1, 1 << 22);
                end
                if (v > longint'(VAL_MAX)) begin
                    v = longint'(VAL_MAX);
                end
            end
            push_write(i, v[DATA_W-1:0]);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key();
        int n;
        int r;
        n = (plan_count > TABLE_DEPTH) ? TABLE_DEPTH : plan_count;
        r = $urandom_range(0, 99);
        if (n == 0 || r >= 83) begin
            return $urandom;
        end else if (r < 55) begin
            return plan_table[$urandom_range(0, n - 1)];
        end else if (r < 75) begin
            return plan_table[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        end
        return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    endfunction

    task automatic issue_queries(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else begin
                push_query(OP_W'($urandom_range(OP_EXACT, OP_LAST)), pick_key());
            end
        end
    endtask

    task automatic run_phase(int n, int queries, bit hold_off);
        int pfx;
        int r;
        int cnt;
        load_sorted(n);
        pfx = written_prefix();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            cnt = n;
        end else if (r < 85) begin
            cnt = $urandom_range(0, n);
        end else if (pfx == TABLE_DEPTH && r < 90) begin
            cnt = $urandom_range(TABLE_DEPTH, (1 << CNT_W) - 1);
        end else begin
            cnt = $urandom_range(0, pfx);
        end
        set_count(cnt);
        if (hold_off) begin
            hold_reqs++;
        end
        issue_queries(queries);
    endtask

    initial begin
        int size;
        int r;
        int phase_no;
        int full_counts[7];
        full_counts = '{TABLE_DEPTH, (1 << CNT_W) - 1, TABLE_DEPTH + 1, 0, 1, 512, 1536};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_count(0);
        push_query(OP_EXACT, 0);
        push_query(OP_FIRST, VAL_MIN);
        push_query(OP_LAST, VAL_MAX);
        push_write(0, VAL_MIN);
        push_write(1, VAL_MIN);
        push_write(2, -5);
        push_write(3, 0);
        push_write(4, 0);
        push_write(5, 0);
        push_write(6, 7);
        push_write(7, VAL_MAX);
        set_count(8);
        push_query(OP_EXACT, 0);
        push_query(OP_FIRST, 0);
        push_query(OP_LAST, 0);
        push_query(OP_FIRST, VAL_MIN);
        push_query(OP_LAST, VAL_MIN);
        push_query(OP_EXACT, VAL_MAX);
        push_query(OP_LAST, VAL_MAX);
        push_query(OP_EXACT, 1);
        push_query(OP_FIRST, -6);
        push_query(OP_LAST, 8);
        push_query(OP_EXACT, -5);
        push_query(OP_FIRST, 7);

        phase_no = 0;
        while (stim_items < SMALL_PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                size = $urandom_range(1, 24);
            end else if (r < 95) begin
                size = $urandom_range(25, 100);
            end else begin
                size = $urandom_range(150, 300);
            end
            run_phase(size, $urandom_range(8, 30), phase_no == 3);
            phase_no++;
        end

        load_sorted(TABLE_DEPTH);
        foreach (full_counts[i]) begin
            set_count(full_counts[i]);
            if (i == 0) begin
                hold_reqs++;
                issue_queries(60);
            end else begin
                issue_queries(15);
            end
        end

        repeat (4) begin
            run_phase($urandom_range(1, 40), $urandom_range(8, 20), 1'b0);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS sorted_table_binary_search");
        end else begin
            $display("FAIL sorted_table_binary_search");
        end
        $finish;
    end

endmodule
